// ----- hdl/imp_pkg.sv -----
// shared types, codes and defaults for the instance mask post-processor
// no dependencies
package imp_pkg;

  localparam int CHANNELS_DEF     = 32;
  localparam int PROTO_WIDTH_DEF  = 160;
  localparam int PROTO_HEIGHT_DEF = 160;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [1:0] FUNC_HEADER = 2'd0;
  localparam logic [1:0] FUNC_COEF   = 2'd1;
  localparam logic [1:0] FUNC_PROTO  = 2'd2;

  localparam logic [2:0] REG_MIN_SCORE       = 3'd0;
  localparam logic [2:0] REG_INVERSE_SCALE   = 3'd1;
  localparam logic [2:0] REG_PAD_X           = 3'd2;
  localparam logic [2:0] REG_PAD_Y           = 3'd3;
  localparam logic [2:0] REG_FRAME_WIDTH     = 3'd4;
  localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd5;
  localparam logic [2:0] REG_PROTO_SCALE_X   = 3'd6;
  localparam logic [2:0] REG_PROTO_SCALE_Y   = 3'd7;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic [15:0]        score;
    logic [7:0]         cls;
    logic [4:0]         channel;
    logic               chan_last;
    logic signed [15:0] value;
  } op_t;

  typedef struct packed {
    logic [15:0] min_score;
    logic [23:0] inverse_scale;
    logic [11:0] pad_x;
    logic [11:0] pad_y;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [16:0] proto_scale_x;
    logic [16:0] proto_scale_y;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic        kept;
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [12:0] box_width;
    logic [12:0] box_height;
    logic [7:0]  out_class;
    logic [15:0] out_score;
    logic        mask_bit;
    logic [7:0]  mask_col;
    logic [7:0]  mask_row;
    logic        last;
  } result_t;

endpackage

// ----- hdl/instance_mask_postprocess.sv -----
// instance mask post-processor: detection verdicts and per-pixel mask bits
// path to a result: queue, three stages, result reg
// throughput: one item per cycle while no result waits, set by the single coefficient mac in the back pipeline
// the back pipeline stalls as a whole while a result waits; the queue keeps taking items until it is full
// reset (rst, synchronous): registers to their defaults, queue and pipeline empty
// depends on imp_pkg, imp_front, imp_fifo, imp_back
module instance_mask_postprocess #(
  parameter int CHANNELS     = imp_pkg::CHANNELS_DEF,
  parameter int PROTO_WIDTH  = imp_pkg::PROTO_WIDTH_DEF,
  parameter int PROTO_HEIGHT = imp_pkg::PROTO_HEIGHT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // configuration writes
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // corner_x1, corner_y1, corner_x2, corner_y2, score, class index, channel, value, pad
  input  logic [111:0] s_axis_tdata,
  // func
  input  logic [1:0]   s_axis_tuser,
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kept, box_x, box_y, box_width, box_height, out_class, out_score,
  // mask_bit, mask_col, mask_row, pad
  output logic [95:0]  m_axis_tdata,
  // kind
  output logic         m_axis_tuser,
  // last pixel of the mask
  output logic         m_axis_tlast
);
  import imp_pkg::*;

  cfg_t    cfg;
  op_t     push_op, pop_op;
  logic    push, full, pop, empty;
  result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_score       <= 16'd16384;
      cfg.inverse_scale   <= 24'd65536;
      cfg.pad_x           <= '0;
      cfg.pad_y           <= '0;
      cfg.frame_width     <= 13'd640;
      cfg.frame_height    <= 13'd480;
      cfg.proto_scale_x   <= 17'd16384;
      cfg.proto_scale_y   <= 17'd16384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_SCORE:       cfg.min_score       <= cfg_data[15:0];
        REG_INVERSE_SCALE:   cfg.inverse_scale   <= cfg_data;
        REG_PAD_X:           cfg.pad_x           <= cfg_data[11:0];
        REG_PAD_Y:           cfg.pad_y           <= cfg_data[11:0];
        REG_FRAME_WIDTH:     cfg.frame_width     <= cfg_data[12:0];
        REG_FRAME_HEIGHT:    cfg.frame_height    <= cfg_data[12:0];
        REG_PROTO_SCALE_X:   cfg.proto_scale_x   <= cfg_data[16:0];
        REG_PROTO_SCALE_Y:   cfg.proto_scale_y   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // front: unpack and classify
  imp_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .push     (push),
    .push_op  (push_op),
    .full     (full)
  );

  // queue decouples front and back
  imp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (empty)
  );

  // back: box math, mac, result register
  imp_back #(
    .CHANNELS     (CHANNELS),
    .PROTO_WIDTH  (PROTO_WIDTH),
    .PROTO_HEIGHT (PROTO_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (empty),
    .q_op      (pop_op),
    .q_pop     (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // result packing, first field lowest
  assign m_axis_tdata = {4'b0000, res.mask_row, res.mask_col, res.mask_bit, res.out_score,
                         res.out_class, res.box_height, res.box_width, res.box_y,
                         res.box_x, res.kept};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ----- hdl/imp_front.sv -----
// front end: unpacks input items, drops ignored ones, tags the last channel
// depends on imp_pkg
module imp_front #(
  parameter int CHANNELS = imp_pkg::CHANNELS_DEF
) (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [111:0]   in_data,
  input  logic [1:0]     in_user,
  output logic           push,
  output imp_pkg::op_t   push_op,
  input  logic           full
);
  import imp_pkg::*;

  logic chan_ok;
  logic keep;

  always_comb begin
    push_op.func      = in_user;
    push_op.x1        = in_data[15:0];
    push_op.y1        = in_data[31:16];
    push_op.x2        = in_data[47:32];
    push_op.y2        = in_data[63:48];
    push_op.score     = in_data[79:64];
    push_op.cls       = in_data[87:80];
    push_op.channel   = in_data[92:88];
    push_op.value     = in_data[108:93];
    push_op.chan_last = (int'(in_data[92:88]) == CHANNELS - 1);
  end

  // out-of-range channels and unknown codes are taken and dropped here
  assign chan_ok  = (int'(in_data[92:88]) < CHANNELS);
  assign keep     = (in_user == FUNC_HEADER) ||
                    (((in_user == FUNC_COEF) || (in_user == FUNC_PROTO)) && chan_ok);
  assign in_ready = !full;
  assign push     = in_valid && !full && keep;

endmodule

// ----- hdl/imp_fifo.sv -----
// short queue of classified items between front and back
// depends on imp_pkg
module imp_fifo #(
  parameter int DEPTH = imp_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  imp_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output imp_pkg::op_t pop_op,
  output logic         empty
);
  import imp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  op_t           mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/imp_back.sv -----
// back end: box mapping pipeline, coefficient store, saturating mac, result register
// depends on imp_pkg
module imp_back #(
  parameter int CHANNELS     = imp_pkg::CHANNELS_DEF,
  parameter int PROTO_WIDTH  = imp_pkg::PROTO_WIDTH_DEF,
  parameter int PROTO_HEIGHT = imp_pkg::PROTO_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  imp_pkg::cfg_t    cfg,
  input  logic             q_empty,
  input  imp_pkg::op_t     q_op,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output imp_pkg::result_t out_res
);
  import imp_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [39:0] ACC_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] ACC_MIN = {1'b1, {39{1'b0}}};

  function automatic logic [32:0] clamp_frame(input logic signed [42:0] v,
                                              input logic [32:0] top);
    logic [32:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > signed'({10'b0, top})) begin
      r = top;
    end else begin
      r = v[32:0];
    end
    return r;
  endfunction

  function automatic logic [12:0] clamp_dim(input logic [12:0] d);
    logic [12:0] r;
    if (d == 13'd0) begin
      r = 13'd1;
    end else if (d > 13'd4096) begin
      r = 13'd4096;
    end else begin
      r = d;
    end
    return r;
  endfunction

  // width of a mapped axis; zero when empty
  function automatic logic [12:0] axis_len(input logic [32:0] lo, input logic [32:0] hi,
                                           input logic [12:0] dim);
    logic [32:0] diff;
    logic [13:0] r;
    logic [12:0] len;
    diff = hi - lo;
    r    = {1'b0, lo[32:20]} + {1'b0, diff[32:20]};
    if (r > {1'b0, dim}) begin
      r = {1'b0, dim};
    end
    len = 13'(r - {1'b0, lo[32:20]});
    if (hi < lo) begin
      len = '0;
    end
    return len;
  endfunction

  function automatic logic signed [15:0] proto_lo(input logic signed [33:0] p);
    logic signed [15:0] l;
    l = 16'(p >>> 20);
    if (l < 0) begin
      l = '0;
    end
    return l;
  endfunction

  function automatic logic signed [15:0] proto_hi(input logic signed [33:0] p,
                                                  input int size);
    logic signed [34:0] s;
    logic signed [15:0] r;
    s = 35'(p) + 35'sd1048575;
    r = 16'(s >>> 20);
    if (r > 16'(size)) begin
      r = 16'(size);
    end
    return r;
  endfunction

  logic adv;
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;

  // stage 1: item, coefficient store
  logic               v1;
  op_t                op1;
  logic signed [15:0] coef [CHANNELS];
  logic [IW-1:0]      idx1;

  assign idx1 = IW'(op1.channel);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= q_op;
      if (v1 && op1.func == FUNC_COEF) begin
        coef[idx1] <= op1.value;
      end
    end
  end

  logic signed [17:0] padx16, pady16;
  logic signed [24:0] inv_s;
  logic signed [17:0] psx_s, psy_s;

  assign padx16 = signed'({2'b00, cfg.pad_x, 4'b0000});
  assign pady16 = signed'({2'b00, cfg.pad_y, 4'b0000});
  assign inv_s  = signed'({1'b0, cfg.inverse_scale});
  assign psx_s  = signed'({1'b0, cfg.proto_scale_x});
  assign psy_s  = signed'({1'b0, cfg.proto_scale_y});

  // stage 2: products
  logic               v2;
  op_t                op2;
  logic               sok2;
  logic signed [42:0] fx1, fx2, fy1, fy2;
  logic signed [33:0] px1, px2, py1, py2;
  logic signed [31:0] mp2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2  <= op1;
      sok2 <= (op1.score >= cfg.min_score);
      fx1  <= (18'(op1.x1) - padx16) * inv_s;
      fx2  <= (18'(op1.x2) - padx16) * inv_s;
      fy1  <= (18'(op1.y1) - pady16) * inv_s;
      fy2  <= (18'(op1.y2) - pady16) * inv_s;
      px1  <= op1.x1 * psx_s;
      px2  <= op1.x2 * psx_s;
      py1  <= op1.y1 * psy_s;
      py2  <= op1.y2 * psy_s;
      mp2  <= coef[idx1] * op1.value;
    end
  end

  // stage 3: clamped edges
  logic               v3;
  op_t                op3;
  logic               sok3;
  logic [12:0]        dimx, dimy, dimx3, dimy3;
  logic [32:0]        lox, hix, loy, hiy;
  logic signed [15:0] pl3, pr3, pt3, pb3;
  logic signed [31:0] mp3;

  assign dimx = clamp_dim(cfg.frame_width);
  assign dimy = clamp_dim(cfg.frame_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op3   <= op2;
      sok3  <= sok2;
      dimx3 <= dimx;
      dimy3 <= dimy;
      lox   <= clamp_frame(fx1, {dimx, 20'b0});
      hix   <= clamp_frame(fx2, {dimx, 20'b0});
      loy   <= clamp_frame(fy1, {dimy, 20'b0});
      hiy   <= clamp_frame(fy2, {dimy, 20'b0});
      pl3   <= proto_lo(px1);
      pr3   <= proto_hi(px2, PROTO_WIDTH);
      pt3   <= proto_lo(py1);
      pb3   <= proto_hi(py2, PROTO_HEIGHT);
      mp3   <= mp2;
    end
  end

  // final stage: state update and result
  logic               active;
  logic [7:0]         box_l, box_t;
  logic [8:0]         box_r, box_b;
  logic signed [39:0] acc;
  logic [7:0]         col, row;

  logic [12:0]        lenx, leny;
  logic               ok;
  logic signed [40:0] sum;
  logic signed [39:0] sat;
  logic               in_box;
  logic               lastpix;
  logic               col_end;
  logic               is_hdr, is_mac, emit;
  result_t            res;

  always_comb begin
    lenx    = axis_len(lox, hix, dimx3);
    leny    = axis_len(loy, hiy, dimy3);
    ok      = sok3 && (lenx != '0) && (leny != '0) && (pr3 > pl3) && (pb3 > pt3);
    sum     = 41'(acc) + 41'(mp3);
    if (sum > 41'(ACC_MAX)) begin
      sat = ACC_MAX;
    end else if (sum < 41'(ACC_MIN)) begin
      sat = ACC_MIN;
    end else begin
      sat = sum[39:0];
    end
    in_box  = (col >= box_l) && ({1'b0, col} < box_r) &&
              (row >= box_t) && ({1'b0, row} < box_b);
    col_end = (int'(col) + 1 >= PROTO_WIDTH);
    lastpix = col_end && (int'(row) + 1 >= PROTO_HEIGHT);
    is_hdr  = v3 && (op3.func == FUNC_HEADER);
    is_mac  = v3 && (op3.func == FUNC_PROTO) && active;
    emit    = is_hdr || (is_mac && op3.chan_last);

    res = '0;
    if (is_hdr) begin
      res.kind       = KIND_VERDICT;
      res.kept       = ok;
      res.box_x      = ok ? lox[31:20] : '0;
      res.box_y      = ok ? loy[31:20] : '0;
      res.box_width  = ok ? lenx : '0;
      res.box_height = ok ? leny : '0;
      res.out_class  = op3.cls;
      res.out_score  = op3.score;
    end else begin
      res.kind     = KIND_PIXEL;
      res.mask_bit = in_box && (sat > 0);
      res.mask_col = col;
      res.mask_row = row;
      res.last     = lastpix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      box_l  <= '0;
      box_t  <= '0;
      box_r  <= '0;
      box_b  <= '0;
      acc    <= '0;
      col    <= '0;
      row    <= '0;
    end else if (adv) begin
      if (is_hdr) begin
        active <= ok;
        acc    <= '0;
        col    <= '0;
        row    <= '0;
        if (ok) begin
          box_l <= pl3[7:0];
          box_t <= pt3[7:0];
          box_r <= pr3[8:0];
          box_b <= pb3[8:0];
        end
      end else if (is_mac) begin
        if (!op3.chan_last) begin
          acc <= sat;
        end else begin
          acc <= '0;
          if (lastpix) begin
            active <= 1'b0;
            col    <= '0;
            row    <= '0;
          end else if (col_end) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_res <= res;
    end
  end

endmodule
